FILE: rtl/core/cfc_pkg.sv
`default_nettype none

package cfc_pkg;

    localparam int unsigned STRIPS_PER_TOWER = 5;
    localparam int unsigned XTALS_PER_STRIP  = 5;
    localparam int unsigned MAX_SAMPLES      = 15;
    localparam int unsigned GAIN_LSB         = 12;

    localparam int unsigned ID_W     = 3;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned GAIN_W   = 2;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned WORD_W   = 16;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    // register reset values
    localparam logic             ZS_RESET  = 1'b1;
    localparam logic [CNT_W-1:0] SPF_RESET = 4'd10;

    // register index, taken from paddr[2]
    typedef enum logic {
        REG_ZERO_SUPPRESSED   = 1'b0,
        REG_SAMPLES_PER_FRAME = 1'b1
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_ID_MISMATCH  = 3'd1,
        ST_ID_RANGE     = 3'd2,
        ST_OUT_OF_ORDER = 3'd3,
        ST_GAIN_ZERO    = 3'd4,
        ST_GAIN_SWITCH  = 3'd5
    } t_status;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_COLLECT = 4'b0010,
        MODE_SKIP    = 4'b0100,
        MODE_ZERO    = 4'b1000
    } t_mode;

endpackage : cfc_pkg

`default_nettype wire

FILE: rtl/core/cfc_if.sv
`default_nettype none

interface cfc_word_if
    import cfc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] word;
    logic              is_header;
    logic [ID_W-1:0]   expected_strip;
    logic [ID_W-1:0]   expected_xtal;
    logic              tower_start;

    modport source (
        output valid, word, is_header, expected_strip, expected_xtal, tower_start,
        input  ready
    );
    modport sink (
        input  valid, word, is_header, expected_strip, expected_xtal, tower_start,
        output ready
    );
endinterface : cfc_word_if

interface cfc_stat_if
    import cfc_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     strip_id;
    logic [ID_W-1:0]     xtal_id;
    logic [CNT_W-1:0]    switch_count;
    logic [CNT_W-1:0]    first_switch;
    logic                frame_accepted;

    modport source (
        output valid, status, strip_id, xtal_id, switch_count, first_switch,
               frame_accepted,
        input  ready
    );
    modport sink (
        input  valid, status, strip_id, xtal_id, switch_count, first_switch,
               frame_accepted,
        output ready
    );
endinterface : cfc_stat_if

`default_nettype wire

FILE: rtl/core/crystal_frame_checker_unit.sv
// channel     dir  handshake     payload
// i_word_if   in   valid/ready   word, is_header, expected_strip/xtal, tower_start
// o_stat_if   out  valid/ready   status, strip_id, xtal_id, switch_count,
//                                first_switch, frame_accepted
// apb         in   psel/penable  zero_suppressed @0x0, samples_per_frame @0x4
//
// One word per cycle. Each word is checked combinationally against the block
// state and any status lands in the output register, shown in the next cycle.
// A word is taken whenever the output register is empty or drains in the same
// cycle; a stalled status holds the input off. Reset is synchronous, active low.
`default_nettype none

module crystal_frame_checker_unit
    import cfc_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    cfc_word_if.sink           i_word_if,
    cfc_stat_if.source         o_stat_if,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [PADDR_W-1:0]  paddr,
    input  wire [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam logic [CNT_W:0] XTAL_MAX  = (CNT_W+1)'(XTALS_PER_STRIP);
    localparam logic [CNT_W:0] STRIP_MAX = (CNT_W+1)'(STRIPS_PER_TOWER);
    localparam logic [CNT_W-1:0] SAMP_MAX = CNT_W'(MAX_SAMPLES);

    // configuration
    logic             r_zs;
    logic [CNT_W-1:0] r_spf;
    t_reg_idx         reg_idx;

    // block state
    logic [ID_W-1:0]   r_last_strip, n_last_strip;
    logic [ID_W-1:0]   r_last_xtal,  n_last_xtal;
    logic [ID_W-1:0]   r_blk_strip,  n_blk_strip;
    logic [ID_W-1:0]   r_blk_xtal,   n_blk_xtal;
    logic [CNT_W-1:0]  r_idx,        n_idx;
    logic [GAIN_W-1:0] r_prev_gain,  n_prev_gain;
    logic [CNT_W-1:0]  r_fall_cnt,   n_fall_cnt;
    logic [CNT_W-1:0]  r_first_fall, n_first_fall;
    t_mode             r_mode,       n_mode;

    // result register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status,   n_status;
    logic [ID_W-1:0]     r_strip_id, n_strip_id;
    logic [ID_W-1:0]     r_xtal_id,  n_xtal_id;
    logic [CNT_W-1:0]    r_sw_cnt,   n_sw_cnt;
    logic [CNT_W-1:0]    r_first_sw, n_first_sw;
    logic                r_accepted, n_accepted;
    logic                n_emit;

    logic              accept;
    logic [ID_W-1:0]   hdr_strip, hdr_xtal, base_strip, base_xtal;
    logic [CNT_W:0]    adv_strip, adv_xtal;
    logic [GAIN_W-1:0] gain;
    logic [CNT_W-1:0]  frame_len;
    logic              id_bad, order_bad;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_comb begin
        case (reg_idx)
            REG_ZERO_SUPPRESSED:   prdata = PDATA_W'(r_zs);
            REG_SAMPLES_PER_FRAME: prdata = PDATA_W'(r_spf);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zs  <= ZS_RESET;
            r_spf <= SPF_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_ZERO_SUPPRESSED:   r_zs  <= pwdata[0];
                REG_SAMPLES_PER_FRAME: r_spf <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_word_if.ready = !r_out_valid || o_stat_if.ready;
    assign accept          = i_word_if.valid && i_word_if.ready;

    assign hdr_strip  = i_word_if.word[ID_W-1:0];
    assign hdr_xtal   = i_word_if.word[4 +: ID_W];
    assign gain       = i_word_if.word[GAIN_LSB +: GAIN_W];
    assign base_strip = i_word_if.tower_start ? '0 : r_last_strip;
    assign base_xtal  = i_word_if.tower_start ? '0 : r_last_xtal;

    always_comb begin
        if (r_spf == '0)
            frame_len = CNT_W'(1);
        else if (r_spf > SAMP_MAX)
            frame_len = SAMP_MAX;
        else
            frame_len = r_spf;
    end

    // next position after the last valid ids; strip wraps only when zero suppressed
    always_comb begin
        adv_xtal  = (CNT_W+1)'(base_xtal) + 1'b1;
        adv_strip = (CNT_W+1)'(base_strip);
        if (adv_xtal > XTAL_MAX) begin
            adv_xtal  = (CNT_W+1)'(1);
            adv_strip = adv_strip + 1'b1;
        end
        if (r_zs && adv_strip > STRIP_MAX) begin
            adv_xtal  = (CNT_W+1)'(1);
            adv_strip = (CNT_W+1)'(1);
        end
    end

    assign id_bad = (hdr_strip == '0) || ((CNT_W+1)'(hdr_strip) > STRIP_MAX) ||
                    (hdr_xtal == '0)  || ((CNT_W+1)'(hdr_xtal) > XTAL_MAX);
    assign order_bad = (hdr_strip == base_strip && hdr_xtal <= base_xtal) ||
                       (hdr_strip < base_strip);

    always_comb begin
        n_last_strip = r_last_strip;
        n_last_xtal  = r_last_xtal;
        n_blk_strip  = r_blk_strip;
        n_blk_xtal   = r_blk_xtal;
        n_idx        = r_idx;
        n_prev_gain  = r_prev_gain;
        n_fall_cnt   = r_fall_cnt;
        n_first_fall = r_first_fall;
        n_mode       = r_mode;
        n_emit       = 1'b0;
        n_status     = ST_OK;
        n_strip_id   = r_blk_strip;
        n_xtal_id    = r_blk_xtal;
        n_sw_cnt     = '0;
        n_first_sw   = '0;
        n_accepted   = 1'b0;

        if (i_word_if.is_header) begin
            n_idx        = '0;
            n_fall_cnt   = '0;
            n_first_fall = '0;
            n_prev_gain  = '0;
            n_last_strip = base_strip;
            n_last_xtal  = base_xtal;
            n_blk_strip  = hdr_strip;
            n_blk_xtal   = hdr_xtal;
            n_mode       = MODE_COLLECT;
            if (!r_zs) begin
                if (hdr_strip != i_word_if.expected_strip ||
                    hdr_xtal != i_word_if.expected_xtal) begin
                    n_last_strip = adv_strip[ID_W-1:0];
                    n_last_xtal  = adv_xtal[ID_W-1:0];
                    n_blk_strip  = i_word_if.expected_strip;
                    n_blk_xtal   = i_word_if.expected_xtal;
                    n_mode       = MODE_SKIP;
                    n_emit       = 1'b1;
                    n_status     = ST_ID_MISMATCH;
                    n_strip_id   = i_word_if.expected_strip;
                    n_xtal_id    = i_word_if.expected_xtal;
                end
            end else if (id_bad || order_bad) begin
                n_last_strip = adv_strip[ID_W-1:0];
                n_last_xtal  = adv_xtal[ID_W-1:0];
                n_blk_strip  = adv_strip[ID_W-1:0];
                n_blk_xtal   = adv_xtal[ID_W-1:0];
                n_mode       = MODE_SKIP;
                n_emit       = 1'b1;
                n_status     = id_bad ? ST_ID_RANGE : ST_OUT_OF_ORDER;
                n_strip_id   = adv_strip[ID_W-1:0];
                n_xtal_id    = adv_xtal[ID_W-1:0];
            end else begin
                n_last_strip = hdr_strip;
                n_last_xtal  = hdr_xtal;
            end
        end else if (r_mode != MODE_IDLE) begin
            if (r_mode == MODE_COLLECT) begin
                if (gain == '0) begin
                    n_mode = MODE_ZERO;
                end else begin
                    if (r_idx != '0 && r_prev_gain > gain) begin
                        n_fall_cnt = r_fall_cnt + 1'b1;
                        if (r_first_fall == '0)
                            n_first_fall = r_idx;
                    end
                    n_prev_gain = gain;
                end
            end
            n_idx = r_idx + 1'b1;
            // end of block
            if (n_idx >= frame_len || n_idx == '0) begin
                n_mode = MODE_IDLE;
                case (r_mode)
                    MODE_SKIP: ;
                    MODE_ZERO: begin
                        n_emit   = 1'b1;
                        n_status = ST_GAIN_ZERO;
                    end
                    default: begin
                        if (n_mode == MODE_IDLE && r_mode == MODE_COLLECT &&
                            gain == '0) begin
                            n_emit   = 1'b1;
                            n_status = ST_GAIN_ZERO;
                        end else begin
                            n_emit = 1'b1;
                            if (n_fall_cnt != '0) begin
                                n_status   = ST_GAIN_SWITCH;
                                n_sw_cnt   = n_fall_cnt;
                                n_first_sw = n_first_fall;
                            end else begin
                                n_status   = ST_OK;
                                n_accepted = 1'b1;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_strip <= '0;
            r_last_xtal  <= '0;
            r_blk_strip  <= '0;
            r_blk_xtal   <= '0;
            r_idx        <= '0;
            r_prev_gain  <= '0;
            r_fall_cnt   <= '0;
            r_first_fall <= '0;
            r_mode       <= MODE_IDLE;
        end else if (accept) begin
            r_last_strip <= n_last_strip;
            r_last_xtal  <= n_last_xtal;
            r_blk_strip  <= n_blk_strip;
            r_blk_xtal   <= n_blk_xtal;
            r_idx        <= n_idx;
            r_prev_gain  <= n_prev_gain;
            r_fall_cnt   <= n_fall_cnt;
            r_first_fall <= n_first_fall;
            r_mode       <= n_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= n_emit;
        end else if (o_stat_if.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && n_emit) begin
            r_status   <= n_status;
            r_strip_id <= n_strip_id;
            r_xtal_id  <= n_xtal_id;
            r_sw_cnt   <= n_sw_cnt;
            r_first_sw <= n_first_sw;
            r_accepted <= n_accepted;
        end
    end

    assign o_stat_if.valid          = r_out_valid;
    assign o_stat_if.status         = r_status;
    assign o_stat_if.strip_id       = r_strip_id;
    assign o_stat_if.xtal_id        = r_xtal_id;
    assign o_stat_if.switch_count   = r_sw_cnt;
    assign o_stat_if.first_switch   = r_first_sw;
    assign o_stat_if.frame_accepted = r_accepted;

endmodule : crystal_frame_checker_unit

`default_nettype wire
